// File: design/spqu_pkg.sv
// ----------------------------------------------------------------------------
// spqu_pkg
// Shared types, codes and defaults for the three-class strict priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spqu_pkg;

   // class codes, in priority order
   localparam logic [1:0] CLASS_HIGH = 2'd0;
   localparam logic [1:0] CLASS_MED  = 2'd1;
   localparam logic [1:0] CLASS_LOW  = 2'd2;
   localparam int         NUM_CLASSES = 3;

   // request operation codes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   // defaults for the top level parameters
   localparam int QUEUE_DEPTH_DEFAULT = 32;
   localparam int DATA_WIDTH_DEFAULT  = 32;

   // command queue between front and back
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int CMD_PTR_W       = $clog2(CMD_QUEUE_DEPTH);
   localparam int CMD_CNT_W       = $clog2(CMD_QUEUE_DEPTH + 1);

   typedef struct packed {
      logic               op;
      logic [1:0]         queue_class;
      logic signed [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] out_value;
      logic               out_valid;
      logic [1:0]         served_class;
      logic [1:0]         status;
      logic               high_empty;
      logic               med_empty;
      logic               low_empty;
   } rsp_word_type;

   typedef enum logic [1:0] {
      CMD_ENQ,
      CMD_DEQ,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   cls;
      logic [31:0]  value;
   } cmd_word_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

endpackage

`default_nettype wire

// File: design/three_class_strict_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// three_class_strict_priority_queue_unit
// Three FIFOs (high, medium, low) with enqueue by class and strict priority
// dequeue; one result word per request word.
// ----------------------------------------------------------------------------
// A request word is decoded on entry and parked in a two-word command queue,
// so requests are still taken while the result side is stalled, until that
// queue is full. The back end takes one command at a time: an enqueue, an
// underflowing dequeue or an enqueue to the unused class code loads the result
// register directly, and a dequeue that finds data first reads the class store,
// whose read port is registered, and loads the result from BK_READ. Sustained
// rate is therefore one word per cycle for enqueues while the result side is
// not stalled, and a dequeue with data holds off the next command until its
// word is loaded into the result register. Each class store holds QUEUE_DEPTH
// words of DATA_WIDTH bits and needs no clearing after reset.
`default_nettype none

module three_class_strict_priority_queue_unit
   import spqu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int DATA_WIDTH  = DATA_WIDTH_DEFAULT
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   logic         cmd_valid;
   cmd_word_type cmd_word;
   logic         cmd_pop;

   spqu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_pop   (cmd_pop)
   );

   spqu_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// File: design/spqu_front.sv
// ----------------------------------------------------------------------------
// spqu_front
// Accepts request words, decodes them into commands and buffers them in a
// small queue that feeds the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module spqu_front
   import spqu_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              cmd_valid,
   output cmd_word_type      cmd_word,
   input  wire logic         cmd_pop
);

   cmd_word_type         queue_ff [CMD_QUEUE_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] cnt_ff, cnt_in;
   cmd_word_type         decoded;
   logic                 push;
   logic                 pop;

   // decode: enqueue to the unused class code does nothing
   always_comb begin
      decoded.cls   = req_word.queue_class;
      decoded.value = req_word.value;
      if (req_word.op == OP_DEQUEUE) begin
         decoded.kind = CMD_DEQ;
      end else if (req_word.queue_class inside {CLASS_HIGH, CLASS_MED, CLASS_LOW}) begin
         decoded.kind = CMD_ENQ;
      end else begin
         decoded.kind = CMD_NOP;
      end
   end

   assign req_stall = (cnt_ff == CMD_CNT_W'(CMD_QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_word  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + CMD_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + CMD_PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CMD_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

// File: design/spqu_back.sv
// ----------------------------------------------------------------------------
// spqu_back
// Executes commands against the three class FIFOs and drives the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module spqu_back
   import spqu_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int DATA_WIDTH  = DATA_WIDTH_DEFAULT
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         cmd_valid,
   input  wire cmd_word_type cmd_word,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   back_state_type  state_ff, state_in;
   logic [PTR_W-1:0] head_ff [NUM_CLASSES];
   logic [PTR_W-1:0] head_in [NUM_CLASSES];
   logic [PTR_W-1:0] tail_ff [NUM_CLASSES];
   logic [PTR_W-1:0] tail_in [NUM_CLASSES];
   logic [CNT_W-1:0] count_ff [NUM_CLASSES];
   logic [CNT_W-1:0] count_in [NUM_CLASSES];
   logic [DATA_WIDTH-1:0] rd_data_ff [NUM_CLASSES];
   logic [1:0]       sel_cls_ff, sel_cls_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic [NUM_CLASSES-1:0] full;
   logic [NUM_CLASSES-1:0] nonempty;
   logic [NUM_CLASSES-1:0] enq_we;
   logic [NUM_CLASSES-1:0] deq_re;
   logic             out_free;
   logic             rsp_load;
   logic [1:0]       rsp_status;
   logic [1:0]       deq_cls;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_sel;
   logic [31:0]      rd_word;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // store keeps the low DATA_WIDTH bits (zero-extended above 32), read side sign-extends to 32 or keeps the low 32
   generate
      if (DATA_WIDTH <= 32) begin : g_narrow
         assign wr_data = cmd_word.value[DATA_WIDTH-1:0];
      end else begin : g_wide
         assign wr_data = {{(DATA_WIDTH-32){1'b0}}, cmd_word.value};
      end
      if (DATA_WIDTH < 32) begin : g_ext
         assign rd_word = {{(32-DATA_WIDTH){rd_sel[DATA_WIDTH-1]}}, rd_sel};
      end else begin : g_trunc
         assign rd_word = rd_sel[31:0];
      end
   endgenerate

   generate
      for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
         logic [DATA_WIDTH-1:0] store_ff [QUEUE_DEPTH];

         assign full[c]     = (count_ff[c] == CNT_W'(QUEUE_DEPTH));
         assign nonempty[c] = (count_ff[c] != '0);

         always_comb begin
            tail_in[c] = tail_ff[c];
            head_in[c] = head_ff[c];
            if (enq_we[c]) begin
               tail_in[c] = (tail_ff[c] == PTR_W'(QUEUE_DEPTH - 1)) ?
                            '0 : tail_ff[c] + PTR_W'(1);
            end
            if (deq_re[c]) begin
               head_in[c] = (head_ff[c] == PTR_W'(QUEUE_DEPTH - 1)) ?
                            '0 : head_ff[c] + PTR_W'(1);
            end
            count_in[c] = count_ff[c] + CNT_W'(enq_we[c]) - CNT_W'(deq_re[c]);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               head_ff[c]  <= '0;
               tail_ff[c]  <= '0;
               count_ff[c] <= '0;
            end else begin
               head_ff[c]  <= head_in[c];
               tail_ff[c]  <= tail_in[c];
               count_ff[c] <= count_in[c];
            end
         end

         always_ff @(posedge clock) begin
            if (enq_we[c]) begin
               store_ff[tail_ff[c]] <= wr_data;
            end
            if (deq_re[c]) begin
               rd_data_ff[c] <= store_ff[head_ff[c]];
            end
         end
      end
   endgenerate

   // strict priority pick
   always_comb begin
      if (nonempty[CLASS_HIGH]) begin
         deq_cls = CLASS_HIGH;
      end else if (nonempty[CLASS_MED]) begin
         deq_cls = CLASS_MED;
      end else begin
         deq_cls = CLASS_LOW;
      end
   end

   always_comb begin
      case (sel_cls_ff)
         CLASS_HIGH: rd_sel = rd_data_ff[CLASS_HIGH];
         CLASS_MED:  rd_sel = rd_data_ff[CLASS_MED];
         default:    rd_sel = rd_data_ff[CLASS_LOW];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && cmd_word.kind == CMD_DEQ && nonempty != '0) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      cmd_pop    = 1'b0;
      rsp_load   = 1'b0;
      rsp_status = STATUS_OK;
      enq_we     = '0;
      deq_re     = '0;
      sel_cls_in = sel_cls_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               case (cmd_word.kind)
                  CMD_ENQ: begin
                     if (out_free) begin
                        cmd_pop  = 1'b1;
                        rsp_load = 1'b1;
                        for (int c = 0; c < NUM_CLASSES; c++) begin
                           enq_we[c] = (cmd_word.cls == 2'(c)) && !full[c];
                        end
                        if ((cmd_word.cls == CLASS_HIGH && full[CLASS_HIGH]) ||
                            (cmd_word.cls == CLASS_MED && full[CLASS_MED]) ||
                            (cmd_word.cls == CLASS_LOW && full[CLASS_LOW])) begin
                           rsp_status = STATUS_OVERFLOW;
                        end
                     end
                  end
                  CMD_DEQ: begin
                     if (nonempty != '0) begin
                        // read issued now, word loaded into result from BK_READ
                        cmd_pop    = 1'b1;
                        sel_cls_in = deq_cls;
                        for (int c = 0; c < NUM_CLASSES; c++) begin
                           deq_re[c] = (deq_cls == 2'(c));
                        end
                     end else if (out_free) begin
                        cmd_pop    = 1'b1;
                        rsp_load   = 1'b1;
                        rsp_status = STATUS_UNDERFLOW;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        cmd_pop  = 1'b1;
                        rsp_load = 1'b1;
                     end
                  end
               endcase
            end
         end
         BK_READ: begin
            rsp_load = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_word_in.out_value    = (state_ff == BK_READ) ? rd_word : '0;
      rsp_word_in.out_valid    = (state_ff == BK_READ);
      rsp_word_in.served_class = (state_ff == BK_READ) ? sel_cls_ff : CLASS_HIGH;
      rsp_word_in.status       = rsp_status;
      rsp_word_in.high_empty   = (count_in[CLASS_HIGH] == '0);
      rsp_word_in.med_empty    = (count_in[CLASS_MED] == '0);
      rsp_word_in.low_empty    = (count_in[CLASS_LOW] == '0);
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_cls_ff <= sel_cls_in;
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire
